// ===== rtl/rids_pkg.sv =====
// Types and constants shared by the RGBA image difference stream.
`default_nettype none
package rids_pkg;

	localparam int unsigned CFG_DATA_W = 13;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned COUNT_W    = 25;
	localparam int unsigned SQ_W       = 18;
	localparam int unsigned WASH_W     = 9;

	typedef logic [7:0]            chan_t;
	typedef logic [11:0]           coord_out_t;
	typedef logic [SQ_W-1:0]       sq_t;
	typedef logic [COUNT_W-1:0]    count_t;
	typedef logic [WASH_W-1:0]     wash_t;
	typedef logic [CFG_DATA_W-1:0] cfg_data_t;
	typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;

	localparam cfg_idx_t CFG_IMAGE_WIDTH  = 2'd0;
	localparam cfg_idx_t CFG_IMAGE_HEIGHT = 2'd1;
	localparam cfg_idx_t CFG_WASH_AMOUNT  = 2'd2;

	localparam cfg_data_t WIDTH_RESET  = 13'd640;
	localparam cfg_data_t HEIGHT_RESET = 13'd480;
	localparam wash_t     WASH_RESET   = 9'd128;
	localparam wash_t     WASH_FULL    = 9'd256;

	localparam chan_t CHAN_MAX = 8'd255;
	localparam chan_t CHAN_MIN = 8'd0;

	typedef struct packed {
		chan_t a_red;
		chan_t a_green;
		chan_t a_blue;
		chan_t a_alpha;
		chan_t b_red;
		chan_t b_green;
		chan_t b_blue;
		chan_t b_alpha;
	} in_t;

	typedef struct packed {
		chan_t      out_red;
		chan_t      out_green;
		chan_t      out_blue;
		chan_t      out_alpha;
		logic       pixel_differs;
		count_t     differing_count;
		sq_t        largest_sq_distance;
		chan_t      largest_channel_gap;
		coord_out_t largest_x;
		coord_out_t largest_y;
		logic       frame_done;
	} out_t;

	// Per-pixel datapath result handed to the statistics unit
	typedef struct packed {
		chan_t red;
		chan_t green;
		chan_t blue;
		chan_t alpha;
		logic  differs;
		sq_t   sq;
		chan_t gap;
	} pix_res_t;

	// Frame statistics after the current pixel
	typedef struct packed {
		count_t     differing_count;
		sq_t        largest_sq;
		chan_t      largest_gap;
		coord_out_t largest_x;
		coord_out_t largest_y;
		logic       frame_done;
	} stats_t;

endpackage
`default_nettype wire

// ===== rtl/rids_pixel.sv =====
// Per-pixel datapath: channel gaps, squared RGB distance, opaque red for differing pixels, else wash toward white.
`default_nettype none
module rids_pixel (
	input  var rids_pkg::in_t      px,
	input  var rids_pkg::wash_t    wash,
	output var rids_pkg::pix_res_t res
);
	import rids_pkg::*;

	function automatic chan_t abs_gap(input chan_t x, input chan_t y);
		return (x > y) ? chan_t'(x - y) : chan_t'(y - x);
	endfunction

	function automatic chan_t wash_chan(input chan_t c, input wash_t w);
		logic [15:0] prod;
		prod = 16'(CHAN_MAX - c) * 16'(w);
		return chan_t'(c + prod[15:8]);
	endfunction

	chan_t       dr, dg, db, da;
	logic [15:0] sr, sg, sb;
	wash_t       w_sat;
	chan_t       gap_rgb;

	always_comb begin
		dr = abs_gap(px.a_red,   px.b_red);
		dg = abs_gap(px.a_green, px.b_green);
		db = abs_gap(px.a_blue,  px.b_blue);
		da = abs_gap(px.a_alpha, px.b_alpha);
		sr = 16'(dr) * 16'(dr);
		sg = 16'(dg) * 16'(dg);
		sb = 16'(db) * 16'(db);
		w_sat = (wash > WASH_FULL) ? WASH_FULL : wash;

		gap_rgb = (dg > dr) ? dg : dr;
		gap_rgb = (db > gap_rgb) ? db : gap_rgb;

		res.sq      = sq_t'(sr) + sq_t'(sg) + sq_t'(sb);
		res.differs = (dr != CHAN_MIN) || (dg != CHAN_MIN) || (db != CHAN_MIN);
		res.gap     = (da > gap_rgb) ? da : gap_rgb;

		if (res.differs) begin
			res.red   = CHAN_MAX;
			res.green = CHAN_MIN;
			res.blue  = CHAN_MIN;
			res.alpha = CHAN_MAX;
		end else begin
			res.red   = wash_chan(px.a_red,   w_sat);
			res.green = wash_chan(px.a_green, w_sat);
			res.blue  = wash_chan(px.a_blue,  w_sat);
			res.alpha = px.a_alpha;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/rids_stats.sv =====
// Raster position counters and per-frame difference statistics.
`default_nettype none
module rids_stats #(
	parameter int unsigned COORD_BITS = 12
) (
	input  var logic                clk,
	input  var logic                arst_n,
	input  var logic                step,
	input  var rids_pkg::pix_res_t  pix,
	input  var rids_pkg::cfg_data_t image_width,
	input  var rids_pkg::cfg_data_t image_height,
	output var rids_pkg::stats_t    stats
);
	import rids_pkg::*;

	// Wide enough for both the size register and 2^COORD_BITS
	localparam int unsigned SW = (COORD_BITS + 1 > CFG_DATA_W) ? COORD_BITS + 1 : CFG_DATA_W;

	typedef logic [COORD_BITS-1:0] coord_t;
	typedef logic [SW-1:0]         size_t;

	localparam size_t SIZE_LIM = size_t'(1) << COORD_BITS;

	function automatic coord_t last_pos(input cfg_data_t v);
		size_t ve;
		size_t eff;
		ve  = size_t'(v);
		eff = (ve == '0) ? size_t'(1) : ((ve > SIZE_LIM) ? SIZE_LIM : ve);
		return coord_t'(eff - size_t'(1));
	endfunction

	coord_t col_q, row_q, best_col_q, best_row_q;
	count_t cnt_q;
	sq_t    best_sq_q;
	chan_t  best_gap_q;

	coord_t last_col, last_row;
	logic   row_end, frame_end, take_best;
	count_t cnt_nxt;
	sq_t    best_sq_nxt;
	chan_t  best_gap_nxt;
	coord_t best_col_nxt, best_row_nxt;

	always_comb begin
		last_col  = last_pos(image_width);
		last_row  = last_pos(image_height);
		row_end   = col_q >= last_col;
		frame_end = row_end && (row_q >= last_row);

		cnt_nxt = cnt_q;
		if (pix.differs && (cnt_q != '1))
			cnt_nxt = cnt_q + count_t'(1);

		// strict compare keeps the first pixel of equal distance
		take_best    = pix.differs && (pix.sq > best_sq_q);
		best_sq_nxt  = take_best ? pix.sq : best_sq_q;
		best_gap_nxt = take_best ? pix.gap : best_gap_q;
		best_col_nxt = take_best ? col_q : best_col_q;
		best_row_nxt = take_best ? row_q : best_row_q;

		stats.differing_count = cnt_nxt;
		stats.largest_sq      = best_sq_nxt;
		stats.largest_gap     = best_gap_nxt;
		stats.largest_x       = coord_out_t'(best_col_nxt);
		stats.largest_y       = coord_out_t'(best_row_nxt);
		stats.frame_done      = frame_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_q      <= '0;
			cnt_q      <= '0;
			best_sq_q  <= '0;
			best_gap_q <= '0;
			best_col_q <= '0;
			best_row_q <= '0;
		end else if (step) begin
			if (frame_end) begin
				col_q      <= '0;
				row_q      <= '0;
				cnt_q      <= '0;
				best_sq_q  <= '0;
				best_gap_q <= '0;
				best_col_q <= '0;
				best_row_q <= '0;
			end else begin
				if (row_end) begin
					col_q <= '0;
					row_q <= row_q + coord_t'(1);
				end else begin
					col_q <= col_q + coord_t'(1);
				end
				cnt_q      <= cnt_nxt;
				best_sq_q  <= best_sq_nxt;
				best_gap_q <= best_gap_nxt;
				best_col_q <= best_col_nxt;
				best_row_q <= best_row_nxt;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/rgba_image_diff_stream.sv =====
// Path: a pixel pair is captured in the input register, its result in the output register.
// Throughput: one pair per cycle unless the output stalls; input register refills meanwhile.
// Statistics update as the item leaves the input register; output stall only
// holds the input side when both registers are full.
// Reset: arst_n clears valids, counters and statistics, and loads the register defaults.
`default_nettype none
module rgba_image_diff_stream #(
	parameter int unsigned COORD_BITS = 12
) (
	input  var logic                clk,
	input  var logic                arst_n,
	input  var logic                cfg_write,
	input  var rids_pkg::cfg_idx_t  cfg_index,
	input  var rids_pkg::cfg_data_t cfg_data,
	input  var logic                in_valid,
	output var logic                in_stall,
	input  var rids_pkg::in_t       in_data,
	output var logic                out_valid,
	input  var logic                out_stall,
	output var rids_pkg::out_t      out_data
);
	import rids_pkg::*;

	cfg_data_t width_q, height_q;
	wash_t     wash_q;

	logic     vld_s1, vld_s2;
	in_t      data_s1;
	out_t     data_s2;
	logic     adv;
	pix_res_t pix;
	stats_t   stats;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
			wash_q   <= WASH_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_IMAGE_WIDTH:  width_q  <= cfg_data;
				CFG_IMAGE_HEIGHT: height_q <= cfg_data;
				CFG_WASH_AMOUNT:  wash_q   <= wash_t'(cfg_data);
				default: ;
			endcase
		end
	end

	assign adv       = !vld_s2 || !out_stall;
	assign in_stall  = vld_s1 && !adv;
	assign out_valid = vld_s2;
	assign out_data  = data_s2;

	rids_pixel u_pixel (
		.px   (data_s1),
		.wash (wash_q),
		.res  (pix)
	);

	rids_stats #(
		.COORD_BITS (COORD_BITS)
	) u_stats (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (vld_s1 && adv),
		.pix          (pix),
		.image_width  (width_q),
		.image_height (height_q),
		.stats        (stats)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (!in_stall)
				vld_s1 <= in_valid;
			if (adv)
				vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall)
			data_s1 <= in_data;
		if (vld_s1 && adv) begin
			data_s2.out_red             <= pix.red;
			data_s2.out_green           <= pix.green;
			data_s2.out_blue            <= pix.blue;
			data_s2.out_alpha           <= pix.alpha;
			data_s2.pixel_differs       <= pix.differs;
			data_s2.differing_count     <= stats.differing_count;
			data_s2.largest_sq_distance <= stats.largest_sq;
			data_s2.largest_channel_gap <= stats.largest_gap;
			data_s2.largest_x           <= stats.largest_x;
			data_s2.largest_y           <= stats.largest_y;
			data_s2.frame_done          <= stats.frame_done;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/rids_checker.sv =====
// Port-level checks for the image difference stream, bound to the top level.
`default_nettype none
module rids_checker (
	input var logic                clk,
	input var logic                arst_n,
	input var logic                out_valid,
	input var logic                out_stall,
	input var rids_pkg::out_t      out_data
);
	import rids_pkg::*;

	// a stalled result transfer holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	a_diff_red: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.pixel_differs |->
			out_data.out_red == CHAN_MAX && out_data.out_green == CHAN_MIN &&
			out_data.out_blue == CHAN_MIN && out_data.out_alpha == CHAN_MAX)
		else $error("differing pixel not opaque red");

	a_diff_stats: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.pixel_differs |->
			out_data.differing_count != '0 && out_data.largest_sq_distance != '0)
		else $error("differing pixel missing from statistics");

	// no largest distance yet means the rest of the record is still clear
	a_best_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.largest_sq_distance == '0 |->
			out_data.largest_channel_gap == CHAN_MIN && out_data.largest_x == '0 &&
			out_data.largest_y == '0)
		else $error("stale largest-difference record");

endmodule

bind rgba_image_diff_stream rids_checker u_rids_checker (.*);
`default_nettype wire

// ===== dv/rids_tb_pkg.sv =====
// Scoreboard for the RGBA image difference stream: pixel predictor and result checks.
`default_nettype none
package rids_tb_pkg;

	import rids_pkg::*;

	localparam int unsigned COORD_LIMIT = 4096;
	localparam int unsigned COORD_MASK  = COORD_LIMIT - 1;
	localparam int unsigned COUNT_MAX   = (1 << COUNT_W) - 1;
	localparam int unsigned REPORT_CAP  = 100;

	class pixel_diff_scoreboard;

		out_t        expected_diffs[$];
		int unsigned mismatches;
		int unsigned results;
		int unsigned frames;

		// shadow registers
		cfg_data_t   width_reg;
		cfg_data_t   height_reg;
		wash_t       wash_reg;

		// shadow frame state
		int unsigned col;
		int unsigned row;
		int unsigned diff_cnt;
		int unsigned best_sq;
		int unsigned best_gap;
		int unsigned best_col;
		int unsigned best_row;

		function new();
			width_reg  = WIDTH_RESET;
			height_reg = HEIGHT_RESET;
			wash_reg   = WASH_RESET;
			col        = 0;
			row        = 0;
			clear_stats();
			mismatches = 0;
			results    = 0;
			frames     = 0;
		endfunction

		function void clear_stats();
			diff_cnt = 0;
			best_sq  = 0;
			best_gap = 0;
			best_col = 0;
			best_row = 0;
		endfunction

		function void set_reg(cfg_idx_t idx, cfg_data_t val);
			case (idx)
				CFG_IMAGE_WIDTH:  width_reg = val;
				CFG_IMAGE_HEIGHT: height_reg = val;
				CFG_WASH_AMOUNT:  wash_reg = val[WASH_W-1:0];
				default: ;
			endcase
		endfunction

		function int unsigned pending();
			return expected_diffs.size();
		endfunction

		static function int unsigned gap_of(chan_t x, chan_t y);
			return (x > y) ? int'(x) - int'(y) : int'(y) - int'(x);
		endfunction

		// zero counts as one, anything past the coordinate range clamps
		static function int unsigned last_pos(cfg_data_t v);
			if (v == 0)
				return 0;
			return ((v > COORD_LIMIT) ? COORD_LIMIT : int'(v)) - 1;
		endfunction

		static function chan_t washed(chan_t c, int unsigned w);
			return chan_t'(int'(c) + (((255 - int'(c)) * w) >> 8));
		endfunction

		function out_t diff_pixel_of(in_t p);
			int unsigned dr, dg, db, da, sq, gap, w, last_col, last_row;
			bit          differs, row_end, frame_end;
			out_t        o;

			dr = gap_of(p.a_red, p.b_red);
			dg = gap_of(p.a_green, p.b_green);
			db = gap_of(p.a_blue, p.b_blue);
			da = gap_of(p.a_alpha, p.b_alpha);
			sq = dr * dr + dg * dg + db * db;
			w = (wash_reg > WASH_FULL) ? WASH_FULL : wash_reg;
			last_col = last_pos(width_reg);
			last_row = last_pos(height_reg);
			differs = (sq != 0);

			if (differs) begin
				if (diff_cnt < COUNT_MAX)
					diff_cnt++;
				// strict compare: the first pixel with the top distance keeps its place
				if (sq > best_sq) begin
					gap = dr;
					if (dg > gap) gap = dg;
					if (db > gap) gap = db;
					if (da > gap) gap = da;
					best_sq  = sq;
					best_gap = gap;
					best_col = col;
					best_row = row;
				end
				o.out_red   = CHAN_MAX;
				o.out_green = CHAN_MIN;
				o.out_blue  = CHAN_MIN;
				o.out_alpha = CHAN_MAX;
			end else begin
				o.out_red   = washed(p.a_red, w);
				o.out_green = washed(p.a_green, w);
				o.out_blue  = washed(p.a_blue, w);
				o.out_alpha = p.a_alpha;
			end

			row_end   = (col >= last_col);
			frame_end = row_end && (row >= last_row);

			o.pixel_differs       = differs;
			o.differing_count     = count_t'(diff_cnt);
			o.largest_sq_distance = sq_t'(best_sq);
			o.largest_channel_gap = chan_t'(best_gap);
			o.largest_x           = coord_out_t'(best_col);
			o.largest_y           = coord_out_t'(best_row);
			o.frame_done          = frame_end;

			if (row_end) begin
				col = 0;
				if (frame_end) begin
					row = 0;
					clear_stats();
				end else begin
					row = (row + 1) & COORD_MASK;
				end
			end else begin
				col = (col + 1) & COORD_MASK;
			end
			return o;
		endfunction

		function void note_pixel(in_t p);
			expected_diffs.push_back(diff_pixel_of(p));
		endfunction

		task report(string msg);
			mismatches++;
			// keep the log bounded on a systematic fault
			if (mismatches <= REPORT_CAP)
				$display("mismatch: %s", msg);
		endtask

		task cmp_field(string name, logic [31:0] got, logic [31:0] want);
			if (got !== want)
				report($sformatf("result %0d %s: got %0h, expected %0h", results, name, got, want));
		endtask

		task check_result(out_t got);
			out_t want;
			results++;
			if (got.frame_done === 1'b1)
				frames++;
			if (expected_diffs.size() == 0) begin
				report($sformatf("result %0d arrived with nothing expected: %h", results, got));
				return;
			end
			want = expected_diffs.pop_front();
			cmp_field("out_red", 32'(got.out_red), 32'(want.out_red));
			cmp_field("out_green", 32'(got.out_green), 32'(want.out_green));
			cmp_field("out_blue", 32'(got.out_blue), 32'(want.out_blue));
			cmp_field("out_alpha", 32'(got.out_alpha), 32'(want.out_alpha));
			cmp_field("pixel_differs", 32'(got.pixel_differs), 32'(want.pixel_differs));
			cmp_field("differing_count", 32'(got.differing_count),
				32'(want.differing_count));
			cmp_field("largest_sq_distance", 32'(got.largest_sq_distance),
				32'(want.largest_sq_distance));
			cmp_field("largest_channel_gap", 32'(got.largest_channel_gap),
				32'(want.largest_channel_gap));
			cmp_field("largest_x", 32'(got.largest_x), 32'(want.largest_x));
			cmp_field("largest_y", 32'(got.largest_y), 32'(want.largest_y));
			cmp_field("frame_done", 32'(got.frame_done), 32'(want.frame_done));
		endtask

	endclass

endpackage
`default_nettype wire

// ===== dv/tb_rgba_image_diff_stream.sv =====
// Testbench top for the RGBA image difference stream: stimulus, handshakes and run control.
`default_nettype none
module tb_rgba_image_diff_stream;

	import rids_pkg::*;
	import rids_tb_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 300000;
	localparam int unsigned RANDOM_ITEMS = 500;
	localparam int unsigned SETTLE       = 6;
	localparam cfg_idx_t    CFG_UNUSED   = 2'd3;

	logic      clk;
	logic      arst_n;
	logic      cfg_write;
	cfg_idx_t  cfg_index;
	cfg_data_t cfg_data;
	logic      in_valid;
	logic      in_stall;
	in_t       in_data;
	logic      out_valid;
	logic      out_stall;
	out_t      out_data;

	pixel_diff_scoreboard sb;
	bit          quiet;
	int unsigned cycle_count;
	int unsigned pixels_sent;
	int unsigned reg_writes;

	rgba_image_diff_stream dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic in_t mk(input chan_t ar, ag, ab, aa, br, bg, bb, ba);
		in_t p;
		p.a_red   = ar;
		p.a_green = ag;
		p.a_blue  = ab;
		p.a_alpha = aa;
		p.b_red   = br;
		p.b_green = bg;
		p.b_blue  = bb;
		p.b_alpha = ba;
		return p;
	endfunction

	function automatic chan_t nudge(chan_t c);
		int v;
		v = $urandom_range(0, 6);
		v = int'(c) + v - 3;
		if (v < 0) v = 0;
		if (v > 255) v = 255;
		return chan_t'(v);
	endfunction

	function automatic in_t rand_pixel();
		in_t p;
		int  r;
		p = in_t'({$urandom, $urandom});
		r = $urandom_range(0, 99);
		if (r < 40) begin
			p.b_red   = p.a_red;
			p.b_green = p.a_green;
			p.b_blue  = p.a_blue;
			if ($urandom_range(0, 1))
				p.b_alpha = p.a_alpha;
		end else if (r < 70) begin
			p.b_red   = nudge(p.a_red);
			p.b_green = nudge(p.a_green);
			p.b_blue  = nudge(p.a_blue);
			p.b_alpha = nudge(p.a_alpha);
		end else if (r < 80) begin
			for (int i = 0; i < 8; i++)
				p[i*8 +: 8] = $urandom_range(0, 1) ? CHAN_MAX : CHAN_MIN;
		end
		return p;
	endfunction

	task automatic send_pixel(in_t p);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= p;
		do
			@(posedge clk);
		while (in_stall);
		sb.note_pixel(p);
		pixels_sent++;
	endtask

	// hold the sender until every outstanding result has been transferred
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, cfg_data_t val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		sb.set_reg(idx, val);
		reg_writes++;
		cfg_write <= 1'b0;
		@(posedge clk);
	endtask

	function automatic cfg_data_t pick_size(int unsigned small_max);
		int r;
		r = $urandom_range(0, 19);
		if (r == 0) return '0;
		if (r == 1) return cfg_data_t'($urandom_range(COORD_LIMIT + 1, 8191));
		if (r == 2) return cfg_data_t'(COORD_LIMIT);
		return cfg_data_t'($urandom_range(1, small_max));
	endfunction

	function automatic cfg_data_t pick_wash();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return '0;
		if (r == 1) return cfg_data_t'(WASH_FULL);
		if (r == 2) return cfg_data_t'($urandom_range(257, 511));
		if (r == 3) return cfg_data_t'(WASH_RESET);
		return cfg_data_t'($urandom_range(0, 511));
	endfunction

	// result side: check every transfer, then stall in bursts
	initial begin : result_sink
		int stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall)
				sb.check_result(out_data);
			if (stall_left > 0)
				stall_left--;
			else
				stall_left = pick_gap();
			out_stall <= (stall_left > 0);
		end
	end

	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d results outstanding", cycle_count, sb.pending());
		$display("FAIL");
		$finish;
	end

	initial begin : stimulus
		int unsigned random_sent;
		int unsigned n;

		sb          = new();
		quiet       = 1'b0;
		pixels_sent = 0;
		reg_writes  = 0;
		random_sent = 0;
		arst_n    <= 1'b0;
		cfg_write <= 1'b0;
		cfg_index <= CFG_IMAGE_WIDTH;
		cfg_data  <= '0;
		in_valid  <= 1'b0;
		in_data   <= '0;
		out_stall <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset defaults first
		send_pixel(mk(0, 0, 0, 0, 0, 0, 0, 0));
		send_pixel(mk(255, 255, 255, 255, 255, 255, 255, 255));
		send_pixel(mk(10, 20, 30, 0, 10, 20, 30, 255));        // alpha alone never counts
		send_pixel(mk(0, 0, 0, 0, 255, 255, 255, 255));        // largest possible distance
		send_pixel(mk(255, 255, 255, 255, 0, 0, 0, 255));      // tie: first keeps its place
		send_pixel(mk(5, 0, 0, 0, 6, 0, 0, 0));
		send_pixel(mk(0, 7, 0, 0, 0, 0, 200, 9));
		drain();
		write_reg(CFG_WASH_AMOUNT, '0);
		send_pixel(mk(77, 88, 99, 11, 77, 88, 99, 22));
		drain();
		write_reg(CFG_WASH_AMOUNT, cfg_data_t'(WASH_FULL));
		send_pixel(mk(1, 128, 254, 3, 1, 128, 254, 3));
		drain();
		write_reg(CFG_WASH_AMOUNT, cfg_data_t'(511));          // saturates to white
		write_reg(CFG_UNUSED, cfg_data_t'($urandom_range(0, 8191)));
		send_pixel(mk(40, 50, 60, 70, 40, 50, 60, 70));
		drain();
		// zero sizes act as one pixel: every transfer closes a frame
		write_reg(CFG_IMAGE_WIDTH, '0);
		write_reg(CFG_IMAGE_HEIGHT, '0);
		write_reg(CFG_WASH_AMOUNT, cfg_data_t'(WASH_RESET));
		send_pixel(mk(10, 10, 10, 0, 12, 10, 10, 200));
		send_pixel(mk(9, 9, 9, 9, 9, 9, 9, 9));
		drain();
		// shrink the row while part-way through it
		write_reg(CFG_IMAGE_WIDTH, cfg_data_t'(8));
		write_reg(CFG_IMAGE_HEIGHT, cfg_data_t'(3));
		repeat (5) send_pixel(rand_pixel());
		drain();
		write_reg(CFG_IMAGE_WIDTH, cfg_data_t'(3));
		repeat (4) send_pixel(rand_pixel());
		drain();
		write_reg(CFG_IMAGE_HEIGHT, cfg_data_t'(1));
		repeat (2) send_pixel(rand_pixel());
		drain();
		write_reg(CFG_IMAGE_WIDTH, cfg_data_t'(8191));
		write_reg(CFG_IMAGE_HEIGHT, cfg_data_t'(8191));
		send_pixel(rand_pixel());

		// random phases, each with fresh settings and a drained pipe
		while (random_sent < RANDOM_ITEMS) begin
			drain();
			quiet = 1'b0;
			write_reg(CFG_IMAGE_WIDTH, pick_size(8));
			write_reg(CFG_IMAGE_HEIGHT, pick_size(6));
			write_reg(CFG_WASH_AMOUNT, pick_wash());
			quiet = ($urandom_range(0, 4) == 0);
			n = $urandom_range(8, 40);
			repeat (n) send_pixel(rand_pixel());
			random_sent += n;
		end

		quiet = 1'b0;
		drain();
		repeat (SETTLE) @(posedge clk);
		if (sb.pending() != 0)
			sb.report($sformatf("%0d expected results never arrived", sb.pending()));
		$display("run covered %0d pixel pairs, %0d results, %0d completed frames, %0d register writes",
			pixels_sent, sb.results, sb.frames, reg_writes);
		$display("sizes 0 to 8191 incl. clamping, wash 0 to 511, size changes part-way through a frame");
		if (sb.mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
`default_nettype wire
